// File: design/ptd_pkg.sv
// ============================================================================
// ptd_pkg
// Shared types and constants for the two-input perceptron trainer: command
// modes, register map, configuration bundle and field widths.
// ============================================================================
package ptd_pkg;

    localparam int STORE_DEPTH_DEF  = 512;
    localparam int COORD_WIDTH_DEF  = 16;
    localparam int WEIGHT_WIDTH_DEF = 32;

    localparam int RATE_WIDTH       = 16;
    localparam int EPOCH_WIDTH      = 10;
    localparam int MIST_WIDTH       = 10;
    localparam int INIT_WIDTH       = 32;
    localparam int OUT_WEIGHT_WIDTH = 32;
    localparam int FRAC_BITS        = 12;

    localparam int APB_DATA_WIDTH   = 32;
    localparam int APB_ADDR_WIDTH   = 5;

    localparam logic [RATE_WIDTH-1:0]  LEARNING_RATE_RESET = 16'd6554;
    localparam logic [EPOCH_WIDTH-1:0] MAX_EPOCHS_RESET    = 10'd100;

    typedef enum logic [1:0] {
        MODE_LOAD    = 2'd0,
        MODE_TRAIN   = 2'd1,
        MODE_PREDICT = 2'd2,
        MODE_CLEAR   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_LEARNING_RATE    = 3'd0,
        REG_MAX_EPOCHS       = 3'd1,
        REG_INIT_WEIGHT_X    = 3'd2,
        REG_INIT_WEIGHT_Y    = 3'd3,
        REG_INIT_WEIGHT_BIAS = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [RATE_WIDTH-1:0]  learning_rate;
        logic [EPOCH_WIDTH-1:0] max_epochs;
        logic [INIT_WIDTH-1:0]  init_weight_x;
        logic [INIT_WIDTH-1:0]  init_weight_y;
        logic [INIT_WIDTH-1:0]  init_weight_bias;
    } cfg_t;

endpackage

// File: design/ptd_cmd_if.sv
// ============================================================================
// ptd_cmd_if
// Command channel: mode plus one labelled sample, valid/ready handshake.
// ============================================================================
interface ptd_cmd_if #(
    parameter int COORD_WIDTH = ptd_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    mode;
    logic signed [COORD_WIDTH-1:0] x_coord;
    logic signed [COORD_WIDTH-1:0] y_coord;
    logic                          label;

    modport source (output valid, mode, x_coord, y_coord, label, input ready);
    modport sink   (input valid, mode, x_coord, y_coord, label, output ready);
endinterface

// File: design/ptd_rsp_if.sv
// ============================================================================
// ptd_rsp_if
// Result channel: one result per command, valid/ready handshake.
// ============================================================================
interface ptd_rsp_if;
    logic                                            valid;
    logic                                            ready;
    logic                                            predicted_class;
    logic [ptd_pkg::EPOCH_WIDTH-1:0]                 epochs_used;
    logic [ptd_pkg::MIST_WIDTH-1:0]                  last_mistakes;
    logic                                            converged;
    logic                                            store_full;
    logic signed [ptd_pkg::OUT_WEIGHT_WIDTH-1:0]     weight_x_out;
    logic signed [ptd_pkg::OUT_WEIGHT_WIDTH-1:0]     weight_y_out;
    logic signed [ptd_pkg::OUT_WEIGHT_WIDTH-1:0]     weight_bias_out;

    modport source (output valid, predicted_class, epochs_used, last_mistakes, converged,
                    store_full, weight_x_out, weight_y_out, weight_bias_out, input ready);
    modport sink   (input valid, predicted_class, epochs_used, last_mistakes, converged,
                    store_full, weight_x_out, weight_y_out, weight_bias_out, output ready);
endinterface

// File: design/ptd_regs.sv
// ============================================================================
// ptd_regs
// APB configuration registers: learning rate, epoch limit, initial weights.
// ============================================================================
module ptd_regs (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [ptd_pkg::APB_ADDR_WIDTH-1:0]    paddr,
    input  logic [ptd_pkg::APB_DATA_WIDTH-1:0]    pwdata,
    output logic [ptd_pkg::APB_DATA_WIDTH-1:0]    prdata,
    output logic                                  pready,
    output ptd_pkg::cfg_t                         cfg
);

    ptd_pkg::cfg_t     cfg_reg;
    ptd_pkg::reg_idx_t reg_idx;
    logic              wr_en;

    assign reg_idx = ptd_pkg::reg_idx_t'(paddr[ptd_pkg::APB_ADDR_WIDTH-1:2]);
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.learning_rate    <= ptd_pkg::LEARNING_RATE_RESET;
            cfg_reg.max_epochs       <= ptd_pkg::MAX_EPOCHS_RESET;
            cfg_reg.init_weight_x    <= '0;
            cfg_reg.init_weight_y    <= '0;
            cfg_reg.init_weight_bias <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                ptd_pkg::REG_LEARNING_RATE:
                    cfg_reg.learning_rate <= pwdata[ptd_pkg::RATE_WIDTH-1:0];
                ptd_pkg::REG_MAX_EPOCHS:
                    cfg_reg.max_epochs <= pwdata[ptd_pkg::EPOCH_WIDTH-1:0];
                ptd_pkg::REG_INIT_WEIGHT_X:
                    cfg_reg.init_weight_x <= pwdata[ptd_pkg::INIT_WIDTH-1:0];
                ptd_pkg::REG_INIT_WEIGHT_Y:
                    cfg_reg.init_weight_y <= pwdata[ptd_pkg::INIT_WIDTH-1:0];
                ptd_pkg::REG_INIT_WEIGHT_BIAS:
                    cfg_reg.init_weight_bias <= pwdata[ptd_pkg::INIT_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            ptd_pkg::REG_LEARNING_RATE:
                prdata = ptd_pkg::APB_DATA_WIDTH'(cfg_reg.learning_rate);
            ptd_pkg::REG_MAX_EPOCHS:
                prdata = ptd_pkg::APB_DATA_WIDTH'(cfg_reg.max_epochs);
            ptd_pkg::REG_INIT_WEIGHT_X:
                prdata = ptd_pkg::APB_DATA_WIDTH'(cfg_reg.init_weight_x);
            ptd_pkg::REG_INIT_WEIGHT_Y:
                prdata = ptd_pkg::APB_DATA_WIDTH'(cfg_reg.init_weight_y);
            ptd_pkg::REG_INIT_WEIGHT_BIAS:
                prdata = ptd_pkg::APB_DATA_WIDTH'(cfg_reg.init_weight_bias);
            default:
                prdata = '0;
        endcase
    end

endmodule

// File: design/perceptron_trainer_2d_unit.sv
// ============================================================================
// perceptron_trainer_2d_unit
// Two-input perceptron trainer with an on-chip sample store.
// ============================================================================
// Commands arrive on the cmd channel (valid/ready); every command returns
// exactly one result on the rsp channel, held in an output register until
// the receiver takes it. A new command is taken while the previous result
// is still waiting only if that result is being taken in the same cycle.
// Load and clear: the result is valid the cycle after the request, and
// loads can stream at one per cycle while rsp is drained. Predict passes
// through a multiply stage, then a sum and compare stage. In training,
// each sample is one read of the single-port sample memory, one multiply
// stage and one sum/update stage, and the next sample waits for the
// updated weights.
// The weights live in registers; the samples live in the memory.
// Reset empties the store, zeroes the weights and loads the default
// register values; no memory clearing pass is needed. A stalled receiver
// blocks new commands once its result register is full.
// ============================================================================
module perceptron_trainer_2d_unit #(
    parameter int STORE_DEPTH  = ptd_pkg::STORE_DEPTH_DEF,
    parameter int COORD_WIDTH  = ptd_pkg::COORD_WIDTH_DEF,
    parameter int WEIGHT_WIDTH = ptd_pkg::WEIGHT_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    ptd_cmd_if.sink                               cmd,
    ptd_rsp_if.source                             rsp,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [ptd_pkg::APB_ADDR_WIDTH-1:0]    paddr,
    input  logic [ptd_pkg::APB_DATA_WIDTH-1:0]    pwdata,
    output logic [ptd_pkg::APB_DATA_WIDTH-1:0]    prdata,
    output logic                                  pready
);

    localparam int C     = COORD_WIDTH;
    localparam int W     = WEIGHT_WIDTH;
    localparam int AW    = $clog2(STORE_DEPTH);
    localparam int CW    = $clog2(STORE_DEPTH + 1);
    localparam int EW    = ptd_pkg::EPOCH_WIDTH;
    localparam int MW    = ptd_pkg::MIST_WIDTH;
    localparam int OWW   = ptd_pkg::OUT_WEIGHT_WIDTH;
    localparam int ENT_W = 2 * C + 1;
    localparam int SD    = C + 3;
    localparam int SF    = C + 19;
    localparam int SUMW  = ((W > SD) ? W : SD) + 2;
    localparam int IW    = (W > ptd_pkg::INIT_WIDTH) ? W : ptd_pkg::INIT_WIDTH;
    localparam int TW    = ((C > ptd_pkg::FRAC_BITS) ? C : ptd_pkg::FRAC_BITS) + W;
    localparam int ACCW  = TW + 2;
    localparam int RW    = ptd_pkg::RATE_WIDTH;
    localparam int BSW   = RW + 14;

    localparam logic signed [W-1:0]  W_MAX      = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]  W_MIN      = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [SF-1:0] STEP_ROUND = SF'(32768);
    localparam logic [BSW-1:0]       BIAS_ROUND = BSW'(32768);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_INIT = 5'b00010,
        S_READ = 5'b00100,
        S_MUL  = 5'b01000,
        S_EVAL = 5'b10000
    } state_t;

    ptd_pkg::cfg_t   cfg;
    ptd_pkg::mode_t  cmd_mode;

    state_t                  state_reg, state_next;
    logic [ENT_W-1:0]        mem [STORE_DEPTH];
    logic [ENT_W-1:0]        rdata_reg;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           idx_reg;
    logic [CW-1:0]           mist_reg;
    logic [EW-1:0]           epoch_reg;
    logic signed [W-1:0]     wx_reg, wy_reg, wb_reg;
    logic [13:0]             bias_step_reg;
    logic                    is_predict_reg;
    logic signed [C-1:0]     x_reg, y_reg;
    logic signed [TW-1:0]    prod_x_reg, prod_y_reg, prod_b_reg;
    logic signed [SD-1:0]    step_x_reg, step_y_reg;
    logic                    lab_reg;

    logic                    rsp_valid_reg;
    logic                    rsp_pred_reg;
    logic [EW-1:0]           rsp_epochs_reg;
    logic [MW-1:0]           rsp_mist_reg;
    logic                    rsp_conv_reg;
    logic                    rsp_full_reg;
    logic signed [W-1:0]     rsp_wx_reg, rsp_wy_reg, rsp_wb_reg;

    logic                    cmd_acc;
    logic                    count_room;
    logic                    rd_en;
    logic                    at_end;
    logic [EW-1:0]           epoch_inc;
    logic                    train_done;
    logic                    produce;
    logic                    res_pred, res_conv, res_full;
    logic [EW-1:0]           res_epochs;
    logic [MW-1:0]           res_mist;
    logic signed [W-1:0]     res_wx, res_wy, res_wb;
    logic [CW+MW-1:0]        mist_ext;

    logic signed [W-1:0]     wx_init, wy_init, wb_init;
    logic [BSW-1:0]          bias_step_full;

    logic signed [C-1:0]     op_x, op_y;
    logic                    op_lab;
    logic signed [RW:0]      rate_s;
    logic signed [TW-1:0]    prod_x, prod_y, prod_b;
    logic signed [SF-1:0]    step_x_full, step_y_full;

    logic signed [ACCW-1:0]  acc;
    logic                    nonneg;
    logic                    wrong;
    logic signed [SUMW-1:0]  dx_s, dy_s, db_s;
    logic signed [SUMW-1:0]  sum_x, sum_y, sum_b;

    logic [W+OWW-1:0]        wx_ext, wy_ext, wb_ext;

    function automatic logic signed [W-1:0] sat_sum(input logic signed [SUMW-1:0] v);
        logic fits;
        fits = (&v[SUMW-1:W-1]) || !(|v[SUMW-1:W-1]);
        if (fits)
            return v[W-1:0];
        else if (v[SUMW-1])
            return W_MIN;
        else
            return W_MAX;
    endfunction

    function automatic logic signed [W-1:0] sat_init(input logic signed [IW-1:0] v);
        logic fits;
        fits = (&v[IW-1:W-1]) || !(|v[IW-1:W-1]);
        if (fits)
            return v[W-1:0];
        else if (v[IW-1])
            return W_MIN;
        else
            return W_MAX;
    endfunction

    ptd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign cmd_mode   = ptd_pkg::mode_t'(cmd.mode);
    assign cmd.ready  = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign cmd_acc    = cmd.valid && cmd.ready;
    assign count_room = count_reg < CW'(STORE_DEPTH);
    assign at_end     = idx_reg == count_reg;
    assign rd_en      = (state_reg == S_READ) && !at_end;
    assign epoch_inc  = epoch_reg + EW'(1);
    assign train_done = (mist_reg == '0) || (epoch_inc == cfg.max_epochs);
    assign mist_ext   = {{MW{1'b0}}, mist_reg};

    // Initial weights and the constant bias step for this training run.
    assign wx_init = sat_init(IW'($signed(cfg.init_weight_x)));
    assign wy_init = sat_init(IW'($signed(cfg.init_weight_y)));
    assign wb_init = sat_init(IW'($signed(cfg.init_weight_bias)));
    assign bias_step_full = (BSW'(cfg.learning_rate) << 13) + BIAS_ROUND;

    // Multiply stage: operands from the memory in training, from the
    // request in predict.
    assign op_x   = is_predict_reg ? x_reg : $signed(rdata_reg[C-1:0]);
    assign op_y   = is_predict_reg ? y_reg : $signed(rdata_reg[2*C-1:C]);
    assign op_lab = rdata_reg[2*C];
    assign rate_s = $signed({1'b0, cfg.learning_rate});
    assign prod_x = TW'(op_x) * TW'(wx_reg);
    assign prod_y = TW'(op_y) * TW'(wy_reg);
    assign prod_b = TW'(wb_reg) <<< ptd_pkg::FRAC_BITS;
    assign step_x_full = ((SF'(rate_s) * SF'(op_x)) <<< 1) + STEP_ROUND;
    assign step_y_full = ((SF'(rate_s) * SF'(op_y)) <<< 1) + STEP_ROUND;

    // Evaluate stage: exact weighted sum, then the perceptron update.
    assign acc    = ACCW'(prod_x_reg) + ACCW'(prod_y_reg) + ACCW'(prod_b_reg);
    assign nonneg = !acc[ACCW-1];
    assign wrong  = nonneg != lab_reg;
    assign dx_s   = SUMW'(step_x_reg);
    assign dy_s   = SUMW'(step_y_reg);
    assign db_s   = SUMW'($signed({1'b0, bias_step_reg}));
    assign sum_x  = lab_reg ? SUMW'(wx_reg) + dx_s : SUMW'(wx_reg) - dx_s;
    assign sum_y  = lab_reg ? SUMW'(wy_reg) + dy_s : SUMW'(wy_reg) - dy_s;
    assign sum_b  = lab_reg ? SUMW'(wb_reg) + db_s : SUMW'(wb_reg) - db_s;

    always_comb
    begin
        state_next = state_reg;
        produce    = 1'b0;
        res_pred   = 1'b0;
        res_epochs = '0;
        res_mist   = '0;
        res_conv   = 1'b0;
        res_full   = 1'b0;
        res_wx     = wx_reg;
        res_wy     = wy_reg;
        res_wb     = wb_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_acc)
                begin
                    unique case (cmd_mode)
                        ptd_pkg::MODE_LOAD:
                        begin
                            produce  = 1'b1;
                            res_full = !count_room;
                        end
                        ptd_pkg::MODE_TRAIN:   state_next = S_INIT;
                        ptd_pkg::MODE_PREDICT: state_next = S_MUL;
                        ptd_pkg::MODE_CLEAR:   produce = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_INIT:
            begin
                if (cfg.max_epochs == '0)
                begin
                    produce    = 1'b1;
                    res_wx     = wx_init;
                    res_wy     = wy_init;
                    res_wb     = wb_init;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (!at_end)
                begin
                    state_next = S_MUL;
                end
                else if (train_done)
                begin
                    produce    = 1'b1;
                    res_epochs = epoch_inc;
                    res_mist   = mist_ext[MW-1:0];
                    res_conv   = mist_reg == '0;
                    state_next = S_IDLE;
                end
            end
            S_MUL:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (is_predict_reg)
                begin
                    produce    = 1'b1;
                    res_pred   = nonneg;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            mist_reg       <= '0;
            epoch_reg      <= '0;
            wx_reg         <= '0;
            wy_reg         <= '0;
            wb_reg         <= '0;
            is_predict_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (produce)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;

            if (cmd_acc)
            begin
                is_predict_reg <= cmd_mode == ptd_pkg::MODE_PREDICT;
                if (cmd_mode == ptd_pkg::MODE_LOAD && count_room)
                    count_reg <= count_reg + CW'(1);
                else if (cmd_mode == ptd_pkg::MODE_CLEAR)
                    count_reg <= '0;
            end

            if (state_reg == S_INIT)
            begin
                wx_reg    <= wx_init;
                wy_reg    <= wy_init;
                wb_reg    <= wb_init;
                epoch_reg <= '0;
                idx_reg   <= '0;
                mist_reg  <= '0;
            end

            // End of a pass that does not finish training: start the next one.
            if (state_reg == S_READ && at_end && !train_done)
            begin
                epoch_reg <= epoch_inc;
                idx_reg   <= '0;
                mist_reg  <= '0;
            end

            if (state_reg == S_EVAL && !is_predict_reg)
            begin
                idx_reg <= idx_reg + CW'(1);
                if (wrong)
                begin
                    wx_reg   <= sat_sum(sum_x);
                    wy_reg   <= sat_sum(sum_y);
                    wb_reg   <= sat_sum(sum_b);
                    mist_reg <= mist_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_acc)
        begin
            x_reg <= cmd.x_coord;
            y_reg <= cmd.y_coord;
        end
        if (state_reg == S_INIT)
            bias_step_reg <= bias_step_full[BSW-1:16];
        if (state_reg == S_MUL)
        begin
            prod_x_reg <= prod_x;
            prod_y_reg <= prod_y;
            prod_b_reg <= prod_b;
            step_x_reg <= step_x_full[SF-1:16];
            step_y_reg <= step_y_full[SF-1:16];
            lab_reg    <= op_lab;
        end
        if (produce)
        begin
            rsp_pred_reg   <= res_pred;
            rsp_epochs_reg <= res_epochs;
            rsp_mist_reg   <= res_mist;
            rsp_conv_reg   <= res_conv;
            rsp_full_reg   <= res_full;
            rsp_wx_reg     <= res_wx;
            rsp_wy_reg     <= res_wy;
            rsp_wb_reg     <= res_wb;
        end
    end

    // Sample memory: one write port for loads, one registered read for training.
    always_ff @(posedge clk)
    begin
        if (cmd_acc && cmd_mode == ptd_pkg::MODE_LOAD && count_room)
            mem[count_reg[AW-1:0]] <= {cmd.label, cmd.y_coord, cmd.x_coord};
        if (rd_en)
            rdata_reg <= mem[idx_reg[AW-1:0]];
    end

    assign wx_ext = {{OWW{rsp_wx_reg[W-1]}}, rsp_wx_reg};
    assign wy_ext = {{OWW{rsp_wy_reg[W-1]}}, rsp_wy_reg};
    assign wb_ext = {{OWW{rsp_wb_reg[W-1]}}, rsp_wb_reg};

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.predicted_class = rsp_pred_reg;
    assign rsp.epochs_used     = rsp_epochs_reg;
    assign rsp.last_mistakes   = rsp_mist_reg;
    assign rsp.converged       = rsp_conv_reg;
    assign rsp.store_full      = rsp_full_reg;
    assign rsp.weight_x_out    = wx_ext[OWW-1:0];
    assign rsp.weight_y_out    = wy_ext[OWW-1:0];
    assign rsp.weight_bias_out = wb_ext[OWW-1:0];

    a_read_written: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> idx_reg < count_reg)
        else $error("sample read beyond the filled part of the store");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STORE_DEPTH))
        else $error("sample count exceeds store depth");

    a_conv_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_conv_reg |-> rsp_mist_reg == '0)
        else $error("converged reported with mistakes in the final pass");

    a_weights_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |=> $stable(wx_reg) && $stable(wy_reg) && $stable(wb_reg))
        else $error("weights changed outside training");

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for perceptron_trainer_2d_unit. A directed table covers
// reset values, extreme coordinates and weights, an empty store, a zero pass
// limit and a zero rate. Random phases then follow. Each phase sets new
// register values, loads a noisy linearly separable sample set, trains and
// predicts. One phase fills the sample store past its depth while the result
// side holds off. Every result is compared with a built-in model of the
// trainer, or for fixed table rows with the value given in the table.
// ============================================================================
module tb;
    import ptd_pkg::*;

    localparam int     RANDOM_ITEMS = 550;
    localparam longint ONE_Q12      = 64'sd1 <<< FRAC_BITS;

    typedef struct packed {
        logic                        predicted_class;
        logic [EPOCH_WIDTH-1:0]      epochs_used;
        logic [MIST_WIDTH-1:0]       last_mistakes;
        logic                        converged;
        logic                        store_full;
        logic [OUT_WEIGHT_WIDTH-1:0] weight_x_out;
        logic [OUT_WEIGHT_WIDTH-1:0] weight_y_out;
        logic [OUT_WEIGHT_WIDTH-1:0] weight_bias_out;
    } result_t;

    typedef struct packed {
        bit          is_write;
        reg_idx_t    reg_sel;
        logic [31:0] reg_value;
        mode_t       mode;
        logic [15:0] x_val;
        logic [15:0] y_val;
        logic        label;
        bit          fixed;
        result_t     want;
    } dir_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_ADDR_WIDTH-1:0] paddr;
    logic [APB_DATA_WIDTH-1:0] pwdata;
    logic [APB_DATA_WIDTH-1:0] prdata;
    logic                      pready;

    ptd_cmd_if cmd_ch ();
    ptd_rsp_if rsp_ch ();

    perceptron_trainer_2d_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Model copy of the configuration, the sample store and the weights.
    cfg_t   cfg_model;
    longint smp_x [STORE_DEPTH_DEF];
    longint smp_y [STORE_DEPTH_DEF];
    bit     smp_label [STORE_DEPTH_DEF];
    int     smp_count = 0;
    longint w_x = 0;
    longint w_y = 0;
    longint w_bias = 0;

    result_t  pending_results[$];
    dir_row_t directed_steps[$];

    int errors      = 0;
    int holds_asked = 0;
    int total_sent  = 0;
    bit quiet       = 1'b0;
    int n_load      = 0;
    int n_train     = 0;
    int n_predict   = 0;
    int n_clear     = 0;
    int n_dropped   = 0;
    int n_converged = 0;
    int most_passes = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("%0t ns: timeout, requests or results stopped moving", $time);
        $display("perceptron_trainer_2d_unit test failed");
        $finish;
    end

    function automatic longint sat_weight(longint v);
        longint hi;
        longint lo;
        hi = longint'(32'h7FFF_FFFF);
        lo = -hi - 1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    // The weighted sum fits easily in 64 bits, so it is evaluated exactly.
    function automatic bit sum_nonneg(longint xc, longint yc);
        return (xc * w_x + yc * w_y + w_bias * ONE_Q12) >= 0;
    endfunction

    function automatic longint weight_step(longint c);
        return (2 * longint'(cfg_model.learning_rate) * c + 32768) >>> 16;
    endfunction

    function automatic result_t trainer_response(mode_t m, logic signed [15:0] xc,
                                                 logic signed [15:0] yc, logic lab);
        result_t r;
        int      passes;
        int      wrong;
        int      j;
        longint  dx;
        longint  dy;
        longint  db;
        r = '0;
        case (m)
            MODE_LOAD:
            begin
                if (smp_count < STORE_DEPTH_DEF)
                begin
                    smp_x[smp_count]     = xc;
                    smp_y[smp_count]     = yc;
                    smp_label[smp_count] = lab;
                    smp_count++;
                end
                else
                begin
                    r.store_full = 1'b1;
                end
            end
            MODE_TRAIN:
            begin
                w_x    = $signed(cfg_model.init_weight_x);
                w_y    = $signed(cfg_model.init_weight_y);
                w_bias = $signed(cfg_model.init_weight_bias);
                passes = 0;
                while (passes < int'(cfg_model.max_epochs) && !r.converged)
                begin
                    wrong = 0;
                    for (j = 0; j < smp_count; j++)
                    begin
                        if (sum_nonneg(smp_x[j], smp_y[j]) != smp_label[j])
                        begin
                            dx = weight_step(smp_x[j]);
                            dy = weight_step(smp_y[j]);
                            db = weight_step(ONE_Q12);
                            if (!smp_label[j])
                            begin
                                dx = -dx;
                                dy = -dy;
                                db = -db;
                            end
                            w_x    = sat_weight(w_x + dx);
                            w_y    = sat_weight(w_y + dy);
                            w_bias = sat_weight(w_bias + db);
                            wrong++;
                        end
                    end
                    passes++;
                    r.last_mistakes = wrong[MIST_WIDTH-1:0];
                    r.converged     = (wrong == 0);
                end
                r.epochs_used = passes[EPOCH_WIDTH-1:0];
            end
            MODE_PREDICT:
            begin
                r.predicted_class = sum_nonneg(xc, yc);
            end
            default:
            begin
                smp_count = 0;
            end
        endcase
        r.weight_x_out    = w_x[31:0];
        r.weight_y_out    = w_y[31:0];
        r.weight_bias_out = w_bias[31:0];
        return r;
    endfunction

    function automatic result_t known(bit pred, int passes, bit conv,
                                      logic [31:0] wx, logic [31:0] wy, logic [31:0] wb);
        result_t r;
        r = '0;
        r.predicted_class = pred;
        r.epochs_used     = passes[EPOCH_WIDTH-1:0];
        r.converged       = conv;
        r.weight_x_out    = wx;
        r.weight_y_out    = wy;
        r.weight_bias_out = wb;
        return r;
    endfunction

    function automatic dir_row_t write_row(reg_idx_t idx, logic [31:0] value);
        dir_row_t d;
        d           = '0;
        d.is_write  = 1'b1;
        d.reg_sel   = idx;
        d.reg_value = value;
        return d;
    endfunction

    function automatic dir_row_t cmd_row(mode_t m, int xv, int yv, bit lab);
        dir_row_t d;
        d       = '0;
        d.mode  = m;
        d.x_val = xv[15:0];
        d.y_val = yv[15:0];
        d.label = lab;
        return d;
    endfunction

    function automatic dir_row_t known_row(mode_t m, int xv, int yv, bit lab, result_t want);
        dir_row_t d;
        d       = cmd_row(m, xv, yv, lab);
        d.fixed = 1'b1;
        d.want  = want;
        return d;
    endfunction

    function automatic logic [15:0] random_coord();
        if ($urandom_range(1) == 1)
            return $urandom;
        return int'($urandom_range(0, 16383)) - 8192;
    endfunction

    function automatic logic [31:0] random_init();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return $urandom;
            default: return int'($urandom_range(0, 32768)) - 16384;
        endcase
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    task automatic compare_result(result_t want, result_t got);
        check_field("predicted_class", want.predicted_class, got.predicted_class);
        check_field("epochs_used", want.epochs_used, got.epochs_used);
        check_field("last_mistakes", want.last_mistakes, got.last_mistakes);
        check_field("converged", want.converged, got.converged);
        check_field("store_full", want.store_full, got.store_full);
        check_field("weight_x_out", want.weight_x_out, got.weight_x_out);
        check_field("weight_y_out", want.weight_y_out, got.weight_y_out);
        check_field("weight_bias_out", want.weight_bias_out, got.weight_bias_out);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_LEARNING_RATE: cfg_model.learning_rate    = value[RATE_WIDTH-1:0];
            REG_MAX_EPOCHS:    cfg_model.max_epochs       = value[EPOCH_WIDTH-1:0];
            REG_INIT_WEIGHT_X: cfg_model.init_weight_x    = value;
            REG_INIT_WEIGHT_Y: cfg_model.init_weight_y    = value;
            default:           cfg_model.init_weight_bias = value;
        endcase
        @(posedge clk);
    endtask

    // Every request yields one result, so an empty queue means the block is idle.
    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_cmd(mode_t m, logic [15:0] xv, logic [15:0] yv, logic lab,
                            bit fixed, result_t want);
        result_t r;
        if (!quiet && $urandom_range(99) < 8)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.mode    <= m;
        cmd_ch.x_coord <= xv;
        cmd_ch.y_coord <= yv;
        cmd_ch.label   <= lab;
        do @(posedge clk); while (cmd_ch.ready !== 1'b1);
        r = trainer_response(m, xv, yv, lab);
        pending_results.push_back(fixed ? want : r);
        total_sent++;
        case (m)
            MODE_LOAD:
            begin
                n_load++;
                n_dropped += r.store_full;
            end
            MODE_TRAIN:
            begin
                n_train++;
                n_converged += r.converged;
                if (int'(r.epochs_used) > most_passes)
                    most_passes = r.epochs_used;
            end
            MODE_PREDICT: n_predict++;
            default:      n_clear++;
        endcase
    endtask

    // One random phase: new register values, then a noisy separable sample
    // set, a training request, predictions and a few arbitrary requests.
    task automatic run_phase();
        cfg_t        pc;
        int          cap;
        int          n_pts;
        int          k;
        longint      sep_a;
        longint      sep_b;
        longint      sep_c;
        logic [15:0] xv;
        logic [15:0] yv;
        logic        lab;
        wait_idle();
        case ($urandom_range(0, 3))
            0: pc.learning_rate = '0;
            1: pc.learning_rate = '1;
            2: pc.learning_rate = LEARNING_RATE_RESET;
            default: pc.learning_rate = $urandom;
        endcase
        case ($urandom_range(0, 9))
            0: pc.max_epochs = '0;
            1: pc.max_epochs = '1;
            2: pc.max_epochs = $urandom_range(100, 1022);
            default: pc.max_epochs = $urandom_range(1, 20);
        endcase
        pc.init_weight_x    = random_init();
        pc.init_weight_y    = random_init();
        pc.init_weight_bias = random_init();
        write_reg(REG_LEARNING_RATE, pc.learning_rate);
        write_reg(REG_MAX_EPOCHS, pc.max_epochs);
        write_reg(REG_INIT_WEIGHT_X, pc.init_weight_x);
        write_reg(REG_INIT_WEIGHT_Y, pc.init_weight_y);
        write_reg(REG_INIT_WEIGHT_BIAS, pc.init_weight_bias);

        // Long pass limits get tiny sample sets to keep training short.
        cap   = (pc.max_epochs > 20) ? 4 : 40;
        sep_a = int'($urandom_range(0, 8)) - 4;
        sep_b = int'($urandom_range(0, 8)) - 4;
        sep_c = int'($urandom_range(0, 4)) - 2;
        send_cmd(MODE_CLEAR, $urandom, $urandom, $urandom, 1'b0, '0);
        n_pts = $urandom_range(1, cap);
        for (k = 0; k < n_pts; k++)
        begin
            xv  = random_coord();
            yv  = random_coord();
            lab = (sep_a * $signed(xv) + sep_b * $signed(yv) + sep_c * ONE_Q12) >= 0;
            if ($urandom_range(99) < 10)
                lab = !lab;
            send_cmd(MODE_LOAD, xv, yv, lab, 1'b0, '0);
            if ($urandom_range(99) < 10)
                send_cmd(MODE_PREDICT, random_coord(), random_coord(), $urandom, 1'b0, '0);
        end
        send_cmd(MODE_TRAIN, $urandom, $urandom, $urandom, 1'b0, '0);
        repeat ($urandom_range(2, 8))
            send_cmd(MODE_PREDICT, random_coord(), random_coord(), $urandom, 1'b0, '0);
        repeat ($urandom_range(0, 3))
            send_cmd(mode_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom, 1'b0, '0);
    endtask

    initial
    begin : result_sink
        int      hold_left;
        int      holds_given;
        result_t got;
        hold_left   = 0;
        holds_given = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                got.predicted_class = rsp_ch.predicted_class;
                got.epochs_used     = rsp_ch.epochs_used;
                got.last_mistakes   = rsp_ch.last_mistakes;
                got.converged       = rsp_ch.converged;
                got.store_full      = rsp_ch.store_full;
                got.weight_x_out    = rsp_ch.weight_x_out;
                got.weight_y_out    = rsp_ch.weight_y_out;
                got.weight_bias_out = rsp_ch.weight_bias_out;
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: result with no request outstanding, got %h", $time, got);
                end
                else
                begin
                    compare_result(pending_results.pop_front(), got);
                end
            end
            if (holds_given != holds_asked)
            begin
                holds_given++;
                hold_left = 200;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= quiet || ($urandom_range(99) >= 8);
            end
        end
    end

    initial
    begin : stimulus
        int       i;
        int       random_start;
        bit       filled;
        dir_row_t d;
        rst_n = 1'b0;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.mode    <= MODE_LOAD;
        cmd_ch.x_coord <= '0;
        cmd_ch.y_coord <= '0;
        cmd_ch.label   <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        cfg_model.learning_rate    = LEARNING_RATE_RESET;
        cfg_model.max_epochs       = MAX_EPOCHS_RESET;
        cfg_model.init_weight_x    = '0;
        cfg_model.init_weight_y    = '0;
        cfg_model.init_weight_bias = '0;

        // Reset state and empty store.
        directed_steps.push_back(known_row(MODE_PREDICT, 0, 0, 0, known(1, 0, 0, 0, 0, 0)));
        directed_steps.push_back(known_row(MODE_TRAIN, 32767, -1, 1, known(0, 1, 1, 0, 0, 0)));
        directed_steps.push_back(known_row(MODE_PREDICT, -32768, 32767, 0,
                                           known(1, 0, 0, 0, 0, 0)));
        directed_steps.push_back(known_row(MODE_LOAD, 32767, 32767, 1, known(0, 0, 0, 0, 0, 0)));
        directed_steps.push_back(known_row(MODE_LOAD, -32768, -32768, 0,
                                           known(0, 0, 0, 0, 0, 0)));
        directed_steps.push_back(known_row(MODE_LOAD, 4096, -4096, 1, known(0, 0, 0, 0, 0, 0)));
        directed_steps.push_back(known_row(MODE_LOAD, -8192, 2048, 0, known(0, 0, 0, 0, 0, 0)));
        directed_steps.push_back(cmd_row(MODE_TRAIN, 0, 0, 0));
        directed_steps.push_back(cmd_row(MODE_PREDICT, 32767, -32768, 0));
        directed_steps.push_back(cmd_row(MODE_PREDICT, 0, 0, 1));
        // Clearing keeps the weights; training an empty store restores the start weights.
        directed_steps.push_back(cmd_row(MODE_CLEAR, -1, -1, 1));
        directed_steps.push_back(known_row(MODE_TRAIN, 0, 0, 0, known(0, 1, 1, 0, 0, 0)));
        // Extreme start weights with a zero pass limit.
        directed_steps.push_back(write_row(REG_INIT_WEIGHT_X, 32'h7FFF_FFFF));
        directed_steps.push_back(write_row(REG_INIT_WEIGHT_Y, 32'h8000_0000));
        directed_steps.push_back(write_row(REG_INIT_WEIGHT_BIAS, 32'h7FFF_FFFF));
        directed_steps.push_back(write_row(REG_MAX_EPOCHS, 0));
        directed_steps.push_back(known_row(MODE_TRAIN, 0, 0, 0,
            known(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF)));
        directed_steps.push_back(cmd_row(MODE_PREDICT, 32767, 32767, 0));
        directed_steps.push_back(cmd_row(MODE_PREDICT, -32768, 32767, 0));
        // Largest rate and pass limit from saturated weights.
        directed_steps.push_back(write_row(REG_LEARNING_RATE, 32'hFFFF));
        directed_steps.push_back(write_row(REG_MAX_EPOCHS, 1023));
        directed_steps.push_back(known_row(MODE_LOAD, 32767, -32768, 0,
            known(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF)));
        directed_steps.push_back(cmd_row(MODE_LOAD, -32768, 32767, 1));
        directed_steps.push_back(cmd_row(MODE_LOAD, 100, -100, 1));
        directed_steps.push_back(cmd_row(MODE_TRAIN, 0, 0, 0));
        directed_steps.push_back(cmd_row(MODE_PREDICT, 1, 1, 0));
        // A zero rate never moves the weights.
        directed_steps.push_back(write_row(REG_LEARNING_RATE, 0));
        directed_steps.push_back(cmd_row(MODE_TRAIN, 0, 0, 0));
        directed_steps.push_back(write_row(REG_LEARNING_RATE, LEARNING_RATE_RESET));
        directed_steps.push_back(write_row(REG_MAX_EPOCHS, MAX_EPOCHS_RESET));
        directed_steps.push_back(write_row(REG_INIT_WEIGHT_X, 0));
        directed_steps.push_back(write_row(REG_INIT_WEIGHT_Y, 0));
        directed_steps.push_back(write_row(REG_INIT_WEIGHT_BIAS, 0));
        directed_steps.push_back(cmd_row(MODE_CLEAR, 0, 0, 0));
        directed_steps.push_back(known_row(MODE_TRAIN, 0, 0, 0, known(0, 1, 1, 0, 0, 0)));
        directed_steps.push_back(known_row(MODE_PREDICT, -1, -1, 0, known(1, 0, 0, 0, 0, 0)));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < directed_steps.size(); i++)
        begin
            d = directed_steps[i];
            if (d.is_write)
            begin
                wait_idle();
                write_reg(d.reg_sel, d.reg_value);
            end
            else
            begin
                send_cmd(d.mode, d.x_val, d.y_val, d.label, d.fixed, d.want);
            end
        end

        random_start = total_sent;
        filled       = 1'b0;
        while (total_sent - random_start < RANDOM_ITEMS)
        begin
            if (!filled && total_sent - random_start >= RANDOM_ITEMS / 2)
            begin
                // Fill the store past its depth with no idling, while the
                // result side first holds off long enough to stall requests.
                wait_idle();
                write_reg(REG_MAX_EPOCHS, 2);
                quiet = 1'b1;
                holds_asked++;
                send_cmd(MODE_CLEAR, $urandom, $urandom, $urandom, 1'b0, '0);
                repeat (STORE_DEPTH_DEF + 2)
                    send_cmd(MODE_LOAD, $urandom, $urandom, $urandom, 1'b0, '0);
                send_cmd(MODE_TRAIN, $urandom, $urandom, $urandom, 1'b0, '0);
                send_cmd(MODE_PREDICT, $urandom, $urandom, $urandom, 1'b0, '0);
                send_cmd(MODE_CLEAR, $urandom, $urandom, $urandom, 1'b0, '0);
                quiet        = 1'b0;
                filled       = 1'b1;
                random_start += STORE_DEPTH_DEF + 5;
            end
            run_phase();
        end

        wait_idle();
        repeat (50) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            errors += pending_results.size();
            $display("%0t ns: %0d results never arrived", $time, pending_results.size());
        end
        $display("Ran %0d requests: %0d loads (%0d dropped on a full store), %0d trains, %0d predicts, %0d clears.",
                 total_sent, n_load, n_dropped, n_train, n_predict, n_clear);
        $display("%0d trainings converged, longest ran %0d passes; %0d mismatches.",
                 n_converged, most_passes, errors);
        if (errors == 0)
            $display("perceptron_trainer_2d_unit test passed");
        else
            $display("perceptron_trainer_2d_unit test failed");
        $finish;
    end

endmodule
